[src/ole_pkg.sv]
`default_nettype none

package ole_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;
    localparam int LENGTH_W = 5;

    localparam int S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((INDEX_W + VALUE_W + LENGTH_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT,
        MODE_INS_BACK,
        MODE_INS_AT,
        MODE_DEL_FRONT,
        MODE_DEL_BACK,
        MODE_DEL_AT,
        MODE_SEARCH,
        MODE_LIST
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_NO_POS,
        ST_NOT_FOUND
    } t_status;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        SRC_COMMIT,
        SRC_CODE,
        SRC_LIST,
        SRC_PEND
    } t_src;

    typedef struct packed {
        logic    load;
        logic    start;
        logic    rd;
        t_rd_sel rd_sel;
        logic    wr_shift;
        logic    ptr_inc;
        logic    pend_set;
        logic    nres_inc;
        logic    commit;
        logic    emit;
        t_src    src;
        t_status code;
        logic    last;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  pos_bad;
        logic  shift_done;
        logic  scan_done;
        logic  match;
        logic  list_last;
        logic  res_limit;
        logic  pend_valid;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

[src/ole_dp.sv]
`default_nettype none

module ole_dp #(
    parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ole_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [ole_pkg::POS_W-1:0]     i_pos,
    input  wire logic [ole_pkg::VALUE_W-1:0]   i_value,
    input  wire ole_pkg::t_cmd                 i_cmd,
    output ole_pkg::t_stat                     o_stat,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ole_pkg::STATUS_W-1:0]       o_status,
    output logic [ole_pkg::INDEX_W-1:0]        o_index,
    output logic [ole_pkg::VALUE_W-1:0]        o_item_value,
    output logic [ole_pkg::LENGTH_W-1:0]       o_length,
    output logic                               o_last
);

    import ole_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] r_mem [DEPTH];

    t_mode              r_mode;
    logic [POS_W-1:0]   r_pos;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_rdata;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_at;
    logic [CW-1:0]      r_pend_idx;
    logic               r_pend_valid;
    logic [NRES_W-1:0]  r_nres;

    logic                r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    logic [INDEX_W-1:0]  r_oindex;
    logic [VALUE_W-1:0]  r_ovalue;
    logic [LENGTH_W-1:0] r_olength;
    logic                r_olast;

    logic               is_ins;
    logic               is_del;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      count_x;
    logic [CW-1:0]      at_calc;
    logic [CW-1:0]      ptr_next;
    logic [CW-1:0]      ptr_prev;
    logic [CW-1:0]      rd_ptr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [CW-1:0]      count_after;
    logic               out_free;

    assign is_ins   = (r_mode inside {MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT});
    assign is_del   = (r_mode inside {MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT});
    assign pos_x    = XW'(r_pos);
    assign count_x  = XW'(r_count);
    assign ptr_next = r_ptr + CW'(1);
    assign ptr_prev = r_ptr - CW'(1);
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        case (r_mode)
            MODE_INS_BACK: at_calc = r_count;
            MODE_INS_AT:   at_calc = (pos_x > count_x) ? r_count : CW'(r_pos);
            MODE_DEL_BACK: at_calc = r_count - CW'(1);
            MODE_DEL_AT:   at_calc = CW'(r_pos);
            default:       at_calc = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: rd_ptr = ptr_prev;
            RD_NEXT: rd_ptr = ptr_next;
            default: rd_ptr = r_ptr;
        endcase
    end

    assign wr_en       = i_cmd.wr_shift || (i_cmd.commit && is_ins);
    assign wr_addr     = i_cmd.wr_shift ? r_ptr[AW-1:0] : r_at[AW-1:0];
    assign wr_data     = i_cmd.wr_shift ? r_rdata : r_value;
    assign count_after = is_ins ? (r_count + CW'(1)) : (r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_ptr[AW-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mode       <= t_mode'(i_mode);
                r_pos        <= i_pos;
                r_value      <= i_value;
                r_nres       <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.start) begin
                r_at <= at_calc;
                if (is_ins) begin
                    r_ptr <= r_count;
                end else if (is_del) begin
                    r_ptr <= at_calc;
                end else begin
                    r_ptr <= '0;
                end
            end
            if (i_cmd.wr_shift) begin
                r_ptr <= is_ins ? ptr_prev : ptr_next;
            end
            if (i_cmd.ptr_inc) begin
                r_ptr <= ptr_next;
            end
            if (i_cmd.pend_set) begin
                r_pend_valid <= 1'b1;
                r_pend_idx   <= r_ptr;
            end
            if (i_cmd.pend_set || i_cmd.nres_inc) begin
                r_nres <= r_nres + NRES_W'(1);
            end
            if (i_cmd.commit) begin
                r_count <= count_after;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                r_olast  <= i_cmd.last;
                case (i_cmd.src)
                    SRC_COMMIT: begin
                        r_ostatus <= ST_OK;
                        r_oindex  <= INDEX_W'(r_at);
                        r_ovalue  <= '0;
                        r_olength <= LENGTH_W'(count_after);
                    end
                    SRC_LIST: begin
                        r_ostatus <= ST_OK;
                        r_oindex  <= INDEX_W'(r_ptr);
                        r_ovalue  <= r_rdata;
                        r_olength <= LENGTH_W'(r_count);
                    end
                    SRC_PEND: begin
                        r_ostatus <= ST_OK;
                        r_oindex  <= INDEX_W'(r_pend_idx);
                        r_ovalue  <= '0;
                        r_olength <= LENGTH_W'(r_count);
                    end
                    default: begin
                        r_ostatus <= i_cmd.code;
                        r_oindex  <= '0;
                        r_ovalue  <= '0;
                        r_olength <= LENGTH_W'(r_count);
                    end
                endcase
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.full       = (r_count == CW'(DEPTH));
        o_stat.empty      = (r_count == '0);
        o_stat.pos_bad    = (pos_x >= count_x);
        o_stat.shift_done = is_ins ? (r_ptr == r_at) : (ptr_next >= r_count);
        o_stat.scan_done  = (r_ptr >= r_count);
        o_stat.match      = (r_rdata == r_value);
        o_stat.res_limit  = (r_nres == NRES_W'(MAX_RESULTS - 1));
        o_stat.list_last  = (ptr_next == r_count) || (r_nres == NRES_W'(MAX_RESULTS - 1));
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_index      = r_oindex;
    assign o_item_value = r_ovalue;
    assign o_length     = r_olength;
    assign o_last       = r_olast;

endmodule

`default_nettype wire

[src/ole_ctrl.sv]
`default_nettype none

module ole_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ole_pkg::t_stat i_stat,
    output ole_pkg::t_cmd       o_cmd
);

    import ole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_COMMIT,
        S_ERROR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SEARCH_END
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;
    logic    is_ins;

    assign is_ins = (i_stat.mode inside {MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_code       = r_code;
        o_ready      = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_PTR;
        o_cmd.src    = SRC_CODE;
        o_cmd.code   = r_code;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.mode)
                    MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                        if (i_stat.full) begin
                            n_code  = ST_FULL;
                            n_state = S_ERROR;
                        end else begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SHIFT_RD;
                        end
                    end
                    MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                        if (i_stat.empty) begin
                            n_code  = ST_EMPTY;
                            n_state = S_ERROR;
                        end else if (i_stat.mode == MODE_DEL_AT && i_stat.pos_bad) begin
                            n_code  = ST_NO_POS;
                            n_state = S_ERROR;
                        end else begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SHIFT_RD;
                        end
                    end
                    MODE_SEARCH: begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN_RD;
                    end
                    default: begin
                        if (i_stat.empty) begin
                            n_code  = ST_EMPTY;
                            n_state = S_ERROR;
                        end else begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = is_ins ? RD_PREV : RD_NEXT;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.src    = SRC_COMMIT;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ERROR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_done) begin
                    n_state = (i_stat.mode == MODE_SEARCH) ? S_SEARCH_END : S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.mode == MODE_LIST) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.src      = SRC_LIST;
                        o_cmd.last     = i_stat.list_last;
                        o_cmd.ptr_inc  = 1'b1;
                        o_cmd.nres_inc = 1'b1;
                        n_state        = i_stat.list_last ? S_IDLE : S_SCAN_RD;
                    end
                end else if (!i_stat.match) begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end else if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.emit     = i_stat.pend_valid;
                    o_cmd.src      = SRC_PEND;
                    o_cmd.pend_set = 1'b1;
                    o_cmd.ptr_inc  = 1'b1;
                    n_state        = i_stat.res_limit ? S_SEARCH_END : S_SCAN_RD;
                end
            end
            S_SEARCH_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = i_stat.pend_valid ? SRC_PEND : SRC_CODE;
                    o_cmd.code = ST_NOT_FOUND;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/ordered_list_engine_top.sv]
`default_nettype none

// Bounded ordered list of signed 32-bit values held in a single-port memory.
// One command arrives per transfer on the s_axis channel: tuser carries the mode,
// tdata the position and the value. Each command yields one or more result
// transfers on the m_axis channel; tlast marks the final result of a command.
// A new command is taken only after the previous one has issued its last
// result into the output register.
// Inserts and deletes move entries one at a time, each with one memory read and
// one write. Search reads one entry at a time. A listing reads one entry at a
// time and delivers one result per entry read, waiting while the output
// register still holds a result that the receiver has not taken.
// Full, empty and bad-position cases answer through an error state with no memory access.
// Reset clears the entry count and the output valid flag; the memory itself is
// not cleared, since only entries below the count are ever read.
// When the receiver stalls, the pending result holds in the output register
// and the engine waits on it before issuing the next one.

module ordered_list_engine_top #(
    parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0: position[4:0], value[36:5], zero pad.
    input  wire logic [ole_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0: mode[2:0].
    input  wire logic [ole_pkg::MODE_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // Fields from bit 0: index[3:0], item_value[35:4], length[40:36], zero pad.
    output logic [ole_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [ole_pkg::STATUS_W-1:0]        o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    import ole_pkg::*;

    localparam int PAD_W = M_TDATA_W - INDEX_W - VALUE_W - LENGTH_W;

    t_cmd                cmd;
    t_stat               stat;
    logic [INDEX_W-1:0]  out_index;
    logic [VALUE_W-1:0]  out_value;
    logic [LENGTH_W-1:0] out_length;

    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ole_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_s_axis_tuser),
        .i_pos        (i_s_axis_tdata[POS_W-1:0]),
        .i_value      (i_s_axis_tdata[POS_W+VALUE_W-1:POS_W]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_status     (o_m_axis_tuser),
        .o_index      (out_index),
        .o_item_value (out_value),
        .o_length     (out_length),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, out_length, out_value, out_index};

endmodule

`default_nettype wire

[dv/ordered_list_checker.sv]
module ordered_list_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    input  wire logic                            i_s_axis_tready,
    // Fields from bit 0: position[4:0], value[36:5], zero pad.
    input  wire logic [ole_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // Fields from bit 0: mode[2:0].
    input  wire logic [ole_pkg::MODE_W-1:0]      i_s_axis_tuser,
    input  wire logic                            i_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // Fields from bit 0: index[3:0], item_value[35:4], length[40:36], zero pad.
    input  wire logic [ole_pkg::M_TDATA_W-1:0]   i_m_axis_tdata,
    // Fields from bit 0: status[2:0].
    input  wire logic [ole_pkg::STATUS_W-1:0]    i_m_axis_tuser,
    input  wire logic                            i_m_axis_tlast,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);

    import ole_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   item_value;
        logic [LENGTH_W-1:0]  length;
        logic                 last;
    } list_result_t;

    list_result_t        expected_results[$];
    logic [VALUE_W-1:0]  entries[DEPTH];
    int unsigned         entry_count = 0;
    int                  mismatch_count = 0;

    task automatic add_result(t_status status, int unsigned idx, logic [VALUE_W-1:0] v);
        list_result_t r;
        r.status     = status;
        r.index      = idx[INDEX_W-1:0];
        r.item_value = v;
        r.length     = entry_count[LENGTH_W-1:0];
        r.last       = 1'b0;
        expected_results.push_back(r);
    endtask

    task automatic apply_list_command(t_mode mode, logic [POS_W-1:0] pos,
                                      logic [VALUE_W-1:0] val);
        int unsigned at;
        int unsigned i;
        int          first;
        first = expected_results.size();
        case (mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                if (entry_count >= DEPTH) begin
                    add_result(ST_FULL, 0, '0);
                end else begin
                    at = (mode == MODE_INS_FRONT) ? 0 :
                         (mode == MODE_INS_BACK) ? entry_count : pos;
                    if (at > entry_count) begin
                        at = entry_count;
                    end
                    for (i = entry_count; i > at; i--) begin
                        entries[i] = entries[i-1];
                    end
                    entries[at] = val;
                    entry_count++;
                    add_result(ST_OK, at, '0);
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                if (entry_count == 0) begin
                    add_result(ST_EMPTY, 0, '0);
                end else begin
                    at = (mode == MODE_DEL_FRONT) ? 0 :
                         (mode == MODE_DEL_BACK) ? entry_count - 1 : pos;
                    if (at >= entry_count) begin
                        add_result(ST_NO_POS, 0, '0);
                    end else begin
                        for (i = at; i + 1 < entry_count; i++) begin
                            entries[i] = entries[i+1];
                        end
                        entry_count--;
                        add_result(ST_OK, at, '0);
                    end
                end
            end
            MODE_SEARCH: begin
                for (i = 0; i < entry_count; i++) begin
                    if (entries[i] == val && expected_results.size() - first < MAX_RESULTS) begin
                        add_result(ST_OK, i, '0);
                    end
                end
                if (expected_results.size() == first) begin
                    add_result(ST_NOT_FOUND, 0, '0);
                end
            end
            MODE_LIST: begin
                for (i = 0; i < entry_count && i < MAX_RESULTS; i++) begin
                    add_result(ST_OK, i, entries[i]);
                end
                if (expected_results.size() == first) begin
                    add_result(ST_EMPTY, 0, '0);
                end
            end
        endcase
        expected_results[expected_results.size()-1].last = 1'b1;
    endtask

    task automatic check_list_result();
        list_result_t got;
        list_result_t want;
        got.status     = t_status'(i_m_axis_tuser);
        got.index      = i_m_axis_tdata[INDEX_W-1:0];
        got.item_value = i_m_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
        got.length     = i_m_axis_tdata[INDEX_W+VALUE_W+LENGTH_W-1:INDEX_W+VALUE_W];
        got.last       = i_m_axis_tlast;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected result: status %0d index %0d value %h length %0d last %0d",
                         got.status, got.index, got.item_value, got.length, got.last);
            end
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch at %0t: expected status %0d index %0d value %h length %0d last %0d",
                             $realtime, want.status, want.index, want.item_value, want.length,
                             want.last);
                    $display("                 actual status %0d index %0d value %h length %0d last %0d",
                             got.status, got.index, got.item_value, got.length, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_count = 0;
            expected_results.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                apply_list_command(t_mode'(i_s_axis_tuser), i_s_axis_tdata[POS_W-1:0],
                                   i_s_axis_tdata[POS_W+VALUE_W-1:POS_W]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                check_list_result();
            end
        end
        o_outstanding <= expected_results.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

[dv/ordered_list_engine_top_tb.sv]
module ordered_list_engine_top_tb;

    import ole_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 205;
    localparam int DRAIN_CYCLES = 60;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = '0;
    logic                   m_tready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic [STATUS_W-1:0]    o_m_axis_tuser;
    logic                   o_m_axis_tlast;
    int                     mismatches;
    int                     outstanding;
    int                     idle_cycles = 0;
    int                     burst_left = 0;
    int                     stall_left = 0;
    int                     stall_style = 0;

    always #10 i_clk = ~i_clk;

    ordered_list_engine_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    ordered_list_checker list_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(8, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= ($urandom_range(0, 19) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_command(t_mode mode, int unsigned pos, logic [VALUE_W-1:0] val);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        word = '0;
        word[POS_W-1:0] = pos[POS_W-1:0];
        word[POS_W+VALUE_W-1:POS_W] = val;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        int                  pick;
        bit                  growing;
        t_mode               mode;
        logic [VALUE_W-1:0]  val;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(MODE_LIST, 0, '0);
        send_command(MODE_SEARCH, 0, '0);
        send_command(MODE_DEL_FRONT, 0, '0);
        send_command(MODE_DEL_BACK, 0, '0);
        send_command(MODE_DEL_AT, 0, '0);
        send_command(MODE_INS_BACK, 0, 32'h8000_0000);
        send_command(MODE_INS_FRONT, 31, 32'h7FFF_FFFF);
        send_command(MODE_INS_AT, 16, 32'h0000_0000);
        send_command(MODE_INS_AT, 1, 32'hFFFF_FFFF);
        send_command(MODE_SEARCH, 0, 32'hFFFF_FFFF);
        send_command(MODE_DEL_AT, 16, '0);
        for (int k = 0; k < 12; k++) begin
            send_command(t_mode'($urandom_range(MODE_INS_FRONT, MODE_INS_AT)),
                         $urandom_range(0, 16), 32'd5);
        end
        send_command(MODE_INS_AT, 3, 32'd9);
        send_command(MODE_SEARCH, 0, 32'd5);
        send_command(MODE_LIST, 0, '0);
        send_command(MODE_DEL_AT, 15, '0);
        send_command(MODE_DEL_BACK, 0, '0);
        send_command(MODE_DEL_FRONT, 0, '0);

        growing = 1'b0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 25 == 0) begin
                growing = !growing;
            end
            pick = $urandom_range(0, 99);
            if (pick < (growing ? 60 : 15)) begin
                mode = t_mode'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
            end else if (pick < 75) begin
                mode = t_mode'($urandom_range(MODE_DEL_FRONT, MODE_DEL_AT));
            end else if (pick < 90) begin
                mode = MODE_SEARCH;
            end else begin
                mode = MODE_LIST;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                val = $urandom_range(0, 7) - 2;
            end else if (pick < 70) begin
                val = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                val = $urandom;
            end
            send_command(mode, $urandom_range(0, 16), val);
        end
        s_tvalid <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
src/ole_pkg.sv
src/ole_dp.sv
src/ole_ctrl.sv
src/ordered_list_engine_top.sv
dv/ordered_list_checker.sv
dv/ordered_list_engine_top_tb.sv
